/* rtl/fbc_pkg.sv */
// Shared types, constants and the round function of the padded Feistel cipher.
package fbc_pkg;

  // Operation codes of the cmd field.
  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  // Defaults of the top-level parameters.
  localparam int unsigned DEF_ROUNDS    = 16;
  localparam int unsigned DEF_KEY_BYTES = 16;

  // Depth of the queue between the front and the back end.
  localparam int unsigned QDEPTH = 4;

  // Block of eight bytes of 0x08 sent after a full final block.
  localparam logic [63:0] PAD_FULL = 64'h0808_0808_0808_0808;

  // Input item.
  typedef struct packed {
    logic        cmd;
    logic [63:0] block_in;
    logic [3:0]  byte_count;
    logic        last_in;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [63:0] block_out;
    logic        last_out;
    logic [3:0]  kept_bytes;
    logic        pad_ok;
  } out_item_t;

  // Classified operation handed from the front to the back end.
  typedef struct packed {
    logic        dec;   // run the inverse rounds
    logic        chk;   // check and strip padding after decryption
    logic        last;  // final result block of the message
    logic [63:0] blk;
  } op_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One Feistel round, forward or inverse, with a zero-extended key byte.
  function automatic logic [63:0] fbc_round(logic [63:0] blk, logic dec, logic [7:0] kb);
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] k;
    l = blk[63:32];
    r = blk[31:0];
    k = {24'd0, kb};
    if (dec) begin
      fbc_round = {r ^ (l + k), l};
    end else begin
      fbc_round = {r, l ^ (r + k)};
    end
  endfunction

endpackage

/* rtl/feistel_block_cipher_padded_core.sv */
// Top level of the padded Feistel block cipher with its key registers.
//
// Usage: items enter on the in channel (in_valid_i, in_stall_o, in_item_i) and
// results leave on the out channel (out_valid_o, out_stall_i, out_item_o); a
// transfer happens at a rising edge with valid high and stall low. Each item
// gives one result, except an encrypted final block of eight bytes, which
// gives its own block and then a full block of padding.
// A result passes from its input transfer through the queue, the round pipeline
// (16 rounds by default) and the output register. Throughput: one item per
// cycle while no stall holds the flow; for a full final encrypt block the
// front end issues the block and then the pad block, one operation per cycle
// into the queue while it is not full. The round pipeline holds one block per stage.
// Reset clears both key registers, the queue and all valid bits. The key is written through
// cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must write it only while the block is idle,
// which the block does not enforce. When the receiver stalls, the whole round pipeline holds;
// the four-entry queue keeps accepting until it fills, then in_stall_o rises.
module feistel_block_cipher_padded_core #(
  parameter int unsigned ROUNDS    = fbc_pkg::DEF_ROUNDS,
  parameter int unsigned KEY_BYTES = fbc_pkg::DEF_KEY_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [63:0]                     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fbc_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fbc_pkg::out_item_t              out_item_o
);

  logic [63:0]      key_low_q;
  logic [63:0]      key_high_q;
  logic             push;
  logic             pop;
  fbc_pkg::op_t     op;
  fbc_pkg::op_t     head;
  fbc_pkg::q_stat_t q_stat;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbc_pkg::REG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        fbc_pkg::REG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  fbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .op_o       (op)
  );

  fbc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (op),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  fbc_back #(
    .ROUNDS    (ROUNDS),
    .KEY_BYTES (KEY_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       ({key_high_q, key_low_q}),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* rtl/fbc_front.sv */
// Front end: accepts input items, applies padding and splits full final blocks in two.
module fbc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  fbc_pkg::in_item_t in_item_i,
  output logic              in_stall_o,
  input  fbc_pkg::q_stat_t  q_stat_i,
  output logic              push_o,
  output fbc_pkg::op_t      op_o
);

  logic        pend_q;
  logic        pend_d;
  logic        accept;
  logic        is_split;
  logic [63:0] padded;
  logic [7:0]  pad_val;

  // A second transfer is owed while the pad block of a full final block waits.
  assign in_stall_o = pend_q | q_stat_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_split   = (in_item_i.cmd == fbc_pkg::CMD_ENC) & in_item_i.last_in &
                      in_item_i.byte_count[3];

  // Replace the trailing bytes of a short final block by the pad count.
  always_comb begin
    pad_val = 8'd8 - {5'd0, in_item_i.byte_count[2:0]};
    padded  = in_item_i.block_in;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) >= in_item_i.byte_count) begin
        padded[56-8*i +: 8] = pad_val;
      end
    end
  end

  // Build the operation pushed into the queue.
  always_comb begin
    op_o = '0;
    if (pend_q) begin
      op_o.dec  = fbc_pkg::CMD_DEC == fbc_pkg::CMD_ENC;
      op_o.chk  = 1'b0;
      op_o.last = 1'b1;
      op_o.blk  = fbc_pkg::PAD_FULL;
    end else if (in_item_i.cmd == fbc_pkg::CMD_DEC) begin
      op_o.dec  = 1'b1;
      op_o.chk  = in_item_i.last_in;
      op_o.last = in_item_i.last_in;
      op_o.blk  = in_item_i.block_in;
    end else begin
      op_o.dec  = 1'b0;
      op_o.chk  = 1'b0;
      op_o.last = in_item_i.last_in & ~is_split;
      op_o.blk  = (in_item_i.last_in & ~is_split) ? padded : in_item_i.block_in;
    end
  end

  assign push_o = pend_q ? ~q_stat_i.full : accept;

  always_comb begin
    pend_d = pend_q;
    if (pend_q && !q_stat_i.full) begin
      pend_d = 1'b0;
    end else if (accept && is_split) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

endmodule

/* rtl/fbc_queue.sv */
// Short queue of classified operations between the front and the back end.
module fbc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fbc_pkg::op_t     op_i,
  input  logic             pop_i,
  output fbc_pkg::op_t     head_o,
  output fbc_pkg::q_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(fbc_pkg::QDEPTH);
  localparam int unsigned CntW = $clog2(fbc_pkg::QDEPTH + 1);

  fbc_pkg::op_t    mem_q [fbc_pkg::QDEPTH];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign stat_o.full  = cnt_q == CntW'(fbc_pkg::QDEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign head_o       = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(fbc_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(fbc_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= op_i;
    end
  end

endmodule

/* rtl/fbc_back.sv */
// Back end: one Feistel round per pipeline stage, then the padding check and output register.
module fbc_back #(
  parameter int unsigned ROUNDS    = fbc_pkg::DEF_ROUNDS,
  parameter int unsigned KEY_BYTES = fbc_pkg::DEF_KEY_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [127:0]       key_i,
  input  fbc_pkg::op_t       head_i,
  input  fbc_pkg::q_stat_t   q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fbc_pkg::out_item_t out_item_o
);

  logic               adv;
  logic [ROUNDS-1:0]  vld_q;
  logic [ROUNDS-1:0]  vld_d;
  fbc_pkg::op_t       stg_q [ROUNDS];
  fbc_pkg::op_t       stg_d [ROUNDS];
  fbc_pkg::op_t       tail;
  logic               out_vld_q;
  fbc_pkg::out_item_t out_q;
  fbc_pkg::out_item_t out_d;
  logic [7:0]         p;
  logic               bad;

  // The whole pipeline moves when the output register is free or being taken.
  assign adv   = ~out_vld_q | ~out_stall_i;
  assign pop_o = adv & ~q_stat_i.empty;

  for (genvar j = 0; j < ROUNDS; j++) begin : g_stage
    localparam int unsigned EncIdx = (j % KEY_BYTES) % 16;
    localparam int unsigned DecIdx = ((ROUNDS - 1 - j) % KEY_BYTES) % 16;
    fbc_pkg::op_t src;
    logic [7:0]   kb;

    if (j == 0) begin : g_first
      assign src      = head_i;
      assign vld_d[j] = ~q_stat_i.empty;
    end else begin : g_rest
      assign src      = stg_q[j-1];
      assign vld_d[j] = vld_q[j-1];
    end

    // Encryption walks the key bytes forwards, decryption backwards.
    assign kb = src.dec ? key_i[8*DecIdx +: 8] : key_i[8*EncIdx +: 8];

    // Next contents of this stage: the control bits ride along with the block.
    assign stg_d[j] = '{dec: src.dec, chk: src.chk, last: src.last,
                        blk: fbc_pkg::fbc_round(src.blk, src.dec, kb)};
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // Stage contents.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < ROUNDS; j++) begin
        stg_q[j] <= stg_d[j];
      end
    end
  end

  assign tail = stg_q[ROUNDS-1];

  // Padding check on the final decrypted block.
  always_comb begin
    p   = tail.blk[7:0];
    bad = (p == 8'd0) || (p > 8'd8);
    for (int i = 0; i < 8; i++) begin
      if ((5'(i) + {1'b0, p[3:0]} >= 5'd8) && (tail.blk[56-8*i +: 8] != p)) begin
        bad = 1'b1;
      end
    end
    out_d.block_out  = tail.blk;
    out_d.last_out   = tail.last;
    out_d.kept_bytes = 4'd8;
    out_d.pad_ok     = 1'b0;
    if (tail.chk && !bad) begin
      out_d.kept_bytes = 4'd8 - p[3:0];
      out_d.pad_ok     = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[ROUNDS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule
